// ===== src/work_stealing_task_scheduler_assert.svh =====
// Assertion macros used by the scheduler checker.
`ifndef WORK_STEALING_TASK_SCHEDULER_ASSERT_SVH
`define WORK_STEALING_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define WSTS_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define WSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wsts_pkg.sv =====
// Package: sizes, codes and beat types of the work-stealing task scheduler.
package wsts_pkg;

  localparam int NUM_WORKERS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_BITS   = 16;

  localparam int WID_W       = $clog2(NUM_WORKERS);
  localparam int NCNT_W      = $clog2(NUM_WORKERS + 1);
  localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_WORKERS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

  localparam int FUNC_W      = 2;
  localparam int ACTIVE_W    = 3;
  localparam int CFG_INDEX_W = 1;

  localparam logic [FUNC_W-1:0] FN_SUBMIT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SPAWN  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FETCH  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_WORKERS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_ACCEPTING = 1'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_NONE      = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_EXIT      = 3'd5
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [WID_W-1:0]     worker;
    logic [TASK_BITS-1:0] task_handle;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [TASK_BITS-1:0] task_out;
    logic [WID_W-1:0]     source_queue;
    logic                 stolen;
    logic [TOT_W-1:0]     queued_total;
  } rsp_t;

  typedef struct packed {
    status_t          status;
    logic [WID_W-1:0] source_queue;
    logic             stolen;
    logic [TOT_W-1:0] queued_total;
    logic             deliver;
  } meta_t;

endpackage

// ===== src/wsts_ram.sv =====
// Generic single-port RAM with registered read.
module wsts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/wsts_sched.sv =====
// Queue bookkeeping, steal victim select and task store access for one request.
module wsts_sched import wsts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  req_t                 req,
  input  logic [ACTIVE_W-1:0]  active_workers,
  input  logic                 stop_accepting,
  output meta_t                meta,
  output logic [TASK_BITS-1:0] rd_task
);

  logic [HEAD_W-1:0] head [NUM_WORKERS];
  logic [HEAD_W-1:0] head_next [NUM_WORKERS];
  logic [QCNT_W-1:0] count [NUM_WORKERS];
  logic [QCNT_W-1:0] count_next [NUM_WORKERS];
  logic [WID_W-1:0]  rr;
  logic [WID_W-1:0]  rr_next;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_next;

  logic [NCNT_W-1:0] n;
  logic              local_w;
  logic              found;
  logic [WID_W-1:0]  victim;
  logic [NCNT_W:0]   cand;

  logic [WID_W-1:0]  q;
  logic [WID_W-1:0]  rr_eff;
  logic [NCNT_W-1:0] rr_inc;
  logic              front;
  logic [HEAD_W-1:0] new_head;
  logic [QCNT_W-1:0] last;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;

  function automatic logic [HEAD_W-1:0] ring_add(input logic [HEAD_W-1:0] a,
                                                 input logic [HEAD_W-1:0] b);
    logic [HEAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (HEAD_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (HEAD_W + 1)'(QUEUE_DEPTH);
    end
    return s[HEAD_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [WID_W-1:0] qi,
                                                  input logic [HEAD_W-1:0] pos);
    return ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

  always_comb begin
    if (active_workers == '0) begin
      n = NCNT_W'(1);
    end else if (int'(active_workers) > NUM_WORKERS) begin
      n = NCNT_W'(NUM_WORKERS);
    end else begin
      n = NCNT_W'(active_workers);
    end
    local_w = NCNT_W'(req.worker) < n;
  end

  always_comb begin
    found  = 1'b0;
    victim = '0;
    cand   = '0;
    for (int k = 1; k < NUM_WORKERS; k++) begin
      cand = (NCNT_W + 1)'(req.worker) + (NCNT_W + 1)'(k);
      if (cand >= {1'b0, n}) begin
        cand = cand - {1'b0, n};
      end
      if (!found && (NCNT_W'(k) < n) && (count[cand[WID_W-1:0]] != '0)) begin
        found  = 1'b1;
        victim = cand[WID_W-1:0];
      end
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    rr_next    = rr;
    total_next = total;
    q          = '0;
    rr_eff     = '0;
    rr_inc     = '0;
    front      = 1'b0;
    new_head   = '0;
    last       = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = '0;
    meta              = '0;
    meta.status       = ST_NONE;

    unique case (req.func)
      FN_SUBMIT, FN_SPAWN: begin
        if (stop_accepting) begin
          meta.status = ST_STOPPED;
        end else begin
          if (req.func == FN_SPAWN && local_w) begin
            q     = req.worker;
            front = 1'b1;
          end else begin
            rr_eff  = (NCNT_W'(rr) >= n) ? '0 : rr;
            q       = rr_eff;
            rr_inc  = NCNT_W'(rr_eff) + NCNT_W'(1);
            rr_next = (rr_inc >= n) ? '0 : rr_inc[WID_W-1:0];
          end
          meta.source_queue = q;
          if (count[q] >= QCNT_W'(QUEUE_DEPTH)) begin
            meta.status = ST_FULL;
          end else begin
            meta.status   = ST_QUEUED;
            ram_we        = 1'b1;
            count_next[q] = count[q] + QCNT_W'(1);
            total_next    = total + TOT_W'(1);
            if (front) begin
              new_head     = (head[q] == '0) ? HEAD_W'(QUEUE_DEPTH - 1)
                                             : head[q] - HEAD_W'(1);
              head_next[q] = new_head;
              ram_addr     = slot_addr(q, new_head);
            end else begin
              ram_addr = slot_addr(q, ring_add(head[q], count[q][HEAD_W-1:0]));
            end
          end
        end
      end
      FN_FETCH: begin
        if (stop_accepting && total == '0) begin
          meta.status = ST_EXIT;
        end else if (local_w) begin
          if (count[req.worker] != '0) begin
            meta.status       = ST_DELIVERED;
            meta.source_queue = req.worker;
            meta.deliver      = 1'b1;
            ram_re            = 1'b1;
            ram_addr          = slot_addr(req.worker, head[req.worker]);
            head_next[req.worker]  = ring_add(head[req.worker], HEAD_W'(1));
            count_next[req.worker] = count[req.worker] - QCNT_W'(1);
            total_next             = total - TOT_W'(1);
          end else if (found) begin
            meta.status       = ST_DELIVERED;
            meta.source_queue = victim;
            meta.stolen       = 1'b1;
            meta.deliver      = 1'b1;
            last              = count[victim] - QCNT_W'(1);
            ram_re            = 1'b1;
            ram_addr          = slot_addr(victim,
                                          ring_add(head[victim], last[HEAD_W-1:0]));
            count_next[victim] = last;
            total_next         = total - TOT_W'(1);
          end
        end
      end
      default: begin
        meta.status = ST_NONE;
      end
    endcase

    meta.queued_total = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORKERS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      rr    <= '0;
      total <= '0;
    end else if (take) begin
      head  <= head_next;
      count <= count_next;
      rr    <= rr_next;
      total <= total_next;
    end
  end

  wsts_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (take && ram_we),
    .re    (take && ram_re),
    .addr  (ram_addr),
    .wdata (req.task_handle),
    .rdata (rd_task)
  );

endmodule

// ===== src/work_stealing_task_scheduler.sv =====
// Top level of the work-stealing task scheduler: config registers and result pipeline.
//
// Requests enter on the in channel (in_valid/in_ready, payload in_data): an external
// submit, a worker spawn or a worker fetch. Each request beat produces exactly one
// result beat on the out channel (out_valid/out_ready, payload out_data), in order.
// From request beat to result valid, the queue heads and counts are updated and the
// task store access is issued when the request is taken; the store read data is then
// registered into the result register. Throughput is one request per cycle while
// out_ready is high, set by the single store port that each request uses at most once.
// When out_ready is low the result register holds and the middle stage still takes
// one more request; after that in_ready drops until the receiver takes the beat.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; index 0
// sets the active worker count, index 1 the stop flag. Write it only while idle.
// Reset (rst, synchronous) empties all queues, zeroes the round-robin pointer and the
// total, sets four active workers and clears the stop flag; the task store keeps no
// reset value and needs no clearing pass.
module work_stealing_task_scheduler import wsts_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  req_t                   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rsp_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ACTIVE_W-1:0]    cfg_data
);

  logic [ACTIVE_W-1:0]  active_workers;
  logic                 stop_accepting;
  logic                 take;
  logic                 s1_valid;
  logic                 s1_adv;
  meta_t                meta;
  meta_t                s1_meta;
  logic [TASK_BITS-1:0] rd_task;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACTIVE_RESET;
      stop_accepting <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_WORKERS: active_workers <= cfg_data;
        REG_STOP_ACCEPTING: stop_accepting <= cfg_data[0];
      endcase
    end
  end

  wsts_sched u_sched (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .req            (in_data),
    .active_workers (active_workers),
    .stop_accepting (stop_accepting),
    .meta           (meta),
    .rd_task        (rd_task)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= take;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_meta <= meta;
    end
    if (s1_adv && s1_valid) begin
      out_data.status       <= s1_meta.status;
      out_data.task_out     <= s1_meta.deliver ? rd_task : '0;
      out_data.source_queue <= s1_meta.source_queue;
      out_data.stolen       <= s1_meta.stolen;
      out_data.queued_total <= s1_meta.queued_total;
    end
  end

endmodule

// ===== src/wsts_checker.sv =====
// Port-level checker for the work-stealing task scheduler, bound to the top level.
`include "work_stealing_task_scheduler_assert.svh"

module wsts_checker import wsts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  `WSTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `WSTS_ASSERT_HOLDS(a_task_zero, out_valid && out_data.status != ST_DELIVERED, out_data.task_out == '0 && !out_data.stolen, "task or steal flag set without a delivery")
  `WSTS_ASSERT_HOLDS(a_exit_drained, out_valid && out_data.status == ST_EXIT, out_data.queued_total == '0, "exit reported with tasks still queued")
  `WSTS_ASSERT_HOLDS(a_total_cap, out_valid, out_data.queued_total <= TOT_W'(STORE_DEPTH), "queued total beyond capacity")

endmodule

bind work_stealing_task_scheduler wsts_checker u_wsts_checker (.*);

// ===== sim/work_stealing_task_scheduler_test.sv =====
// Self-checking testbench for the work-stealing task scheduler.
`timescale 1ns / 100ps

module work_stealing_task_scheduler_test;
  import wsts_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    bit                   cfg;
    logic [ACTIVE_W-1:0]  workers;
    logic [ACTIVE_W-1:0]  stop_word;
    req_t                 req;
    int                   reps;
    bit                   typed;
    rsp_t                 want;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  req_t                   in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rsp_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ACTIVE_WORKERS;
  logic [ACTIVE_W-1:0]    cfg_data = '0;

  // scheduler state mirrored by the predictor
  logic [TASK_BITS-1:0] m_ring[NUM_WORKERS][QUEUE_DEPTH];
  logic [HEAD_W-1:0]    m_head[NUM_WORKERS];
  int unsigned          m_count[NUM_WORKERS];
  int unsigned          m_rr;
  int unsigned          m_total;
  logic [ACTIVE_W-1:0]  m_active;
  logic                 m_stop;

  rsp_t        outcomes_due[$];
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  work_stealing_task_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic rsp_t dispatch_outcome(input req_t r);
    rsp_t              o;
    int                n;
    int                q;
    int                v;
    bit                owner;
    bit                found;
    logic [HEAD_W-1:0] slot_ix;
    n = (m_active == 0) ? 1 : (m_active > NUM_WORKERS) ? NUM_WORKERS : int'(m_active);
    owner = int'(r.worker) < n;
    o = '0;
    o.status = ST_NONE;
    case (r.func)
      FN_SUBMIT, FN_SPAWN: begin
        if (m_stop) begin
          o.status = ST_STOPPED;
        end else begin
          if (r.func == FN_SPAWN && owner) begin
            q = r.worker;
          end else begin
            if (m_rr >= n) m_rr = 0;
            q = m_rr;
            m_rr = (m_rr + 1 >= n) ? 0 : m_rr + 1;
          end
          o.source_queue = WID_W'(q);
          if (m_count[q] >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            if (r.func == FN_SPAWN && owner) begin
              m_head[q] = m_head[q] - 1'b1;
              slot_ix = m_head[q];
            end else begin
              slot_ix = m_head[q] + HEAD_W'(m_count[q]);
            end
            m_ring[q][slot_ix] = r.task_handle;
            m_count[q]++;
            m_total++;
            o.status = ST_QUEUED;
          end
        end
      end
      FN_FETCH: begin
        if (m_stop && m_total == 0) begin
          o.status = ST_EXIT;
        end else if (owner) begin
          q = r.worker;
          if (m_count[q] != 0) begin
            o.task_out = m_ring[q][m_head[q]];
            m_head[q] = m_head[q] + 1'b1;
            m_count[q]--;
            m_total--;
            o.source_queue = WID_W'(q);
            o.status = ST_DELIVERED;
          end else begin
            found = 1'b0;
            for (int k = 1; k < n; k++) begin
              v = (q + k) % n;
              if (!found && m_count[v] != 0) begin
                slot_ix = m_head[v] + HEAD_W'(m_count[v] - 1);
                o.task_out = m_ring[v][slot_ix];
                m_count[v]--;
                m_total--;
                o.source_queue = WID_W'(v);
                o.stolen = 1'b1;
                o.status = ST_DELIVERED;
                found = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.queued_total = TOT_W'(m_total);
    return o;
  endfunction

  function automatic step_t row_req(input logic [FUNC_W-1:0] f, input logic [WID_W-1:0] w,
                                    input logic [TASK_BITS-1:0] h, input int reps);
    step_t s;
    s = '{default: '0};
    s.req = '{func: f, worker: w, task_handle: h};
    s.reps = reps;
    return s;
  endfunction

  function automatic step_t row_typed(input logic [FUNC_W-1:0] f, input logic [WID_W-1:0] w,
                                      input logic [TASK_BITS-1:0] h, input status_t st,
                                      input logic [TASK_BITS-1:0] t, input logic [WID_W-1:0] src,
                                      input logic stl, input logic [TOT_W-1:0] tot);
    step_t s;
    s = row_req(f, w, h, 1);
    s.typed = 1'b1;
    s.want = '{status: st, task_out: t, source_queue: src, stolen: stl, queued_total: tot};
    return s;
  endfunction

  function automatic step_t row_cfg(input logic [ACTIVE_W-1:0] workers,
                                    input logic [ACTIVE_W-1:0] stop_word);
    step_t s;
    s = '{default: '0};
    s.cfg = 1'b1;
    s.workers = workers;
    s.stop_word = stop_word;
    return s;
  endfunction

  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    int   gap;
    rsp_t model;
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = dispatch_outcome(r);
    outcomes_due.push_back(typed ? want : model);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_pool(input logic [ACTIVE_W-1:0] workers,
                          input logic [ACTIVE_W-1:0] stop_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ACTIVE_WORKERS;
    cfg_data <= workers;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_active = workers;
    cfg_index <= REG_STOP_ACCEPTING;
    cfg_data <= stop_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_stop = stop_word[0];
    cfg_valid <= 1'b0;
  endtask

  initial begin : driver
    step_t               script[$];
    req_t                r;
    int                  roll;
    int                  push_pct;
    logic [ACTIVE_W-1:0] workers_w;
    logic [ACTIVE_W-1:0] stop_w;
    for (int q = 0; q < NUM_WORKERS; q++) begin
      m_head[q] = '0;
      m_count[q] = 0;
    end
    m_rr = 0;
    m_total = 0;
    m_active = ACTIVE_RESET;
    m_stop = 1'b0;

    script = '{
      row_typed(FN_FETCH,  2'd0, 16'h0000, ST_NONE,      16'h0000, 2'd0, 1'b0, 7'd0),
      row_typed(FN_SUBMIT, 2'd3, 16'hFFFF, ST_QUEUED,    16'h0000, 2'd0, 1'b0, 7'd1),
      row_typed(FN_SUBMIT, 2'd0, 16'h0000, ST_QUEUED,    16'h0000, 2'd1, 1'b0, 7'd2),
      row_typed(FN_SPAWN,  2'd3, 16'hA5A5, ST_QUEUED,    16'h0000, 2'd3, 1'b0, 7'd3),
      row_typed(FN_SPAWN,  2'd2, 16'h5A5A, ST_QUEUED,    16'h0000, 2'd2, 1'b0, 7'd4),
      row_typed(FN_FETCH,  2'd0, 16'h0000, ST_DELIVERED, 16'hFFFF, 2'd0, 1'b0, 7'd3),
      row_typed(FN_FETCH,  2'd0, 16'h0000, ST_DELIVERED, 16'h0000, 2'd1, 1'b1, 7'd2),
      row_typed(FN_FETCH,  2'd1, 16'h0000, ST_DELIVERED, 16'h5A5A, 2'd2, 1'b1, 7'd1),
      row_typed(FN_FETCH,  2'd1, 16'h0000, ST_DELIVERED, 16'hA5A5, 2'd3, 1'b1, 7'd0),
      row_typed(FN_UNUSED, 2'd2, 16'h1234, ST_NONE,      16'h0000, 2'd0, 1'b0, 7'd0),
      row_cfg(3'd7, 3'b111),
      row_typed(FN_SUBMIT, 2'd0, 16'h1111, ST_STOPPED,   16'h0000, 2'd0, 1'b0, 7'd0),
      row_typed(FN_SPAWN,  2'd1, 16'h2222, ST_STOPPED,   16'h0000, 2'd0, 1'b0, 7'd0),
      row_typed(FN_FETCH,  2'd2, 16'h0000, ST_EXIT,      16'h0000, 2'd0, 1'b0, 7'd0),
      row_cfg(3'd1, 3'b110),
      row_req(FN_SPAWN,  2'd3, 16'hBEEF, 1),
      row_req(FN_SPAWN,  2'd1, 16'hCAFE, 1),
      row_req(FN_FETCH,  2'd3, 16'h0000, 1),
      row_req(FN_FETCH,  2'd0, 16'h0000, 1),
      row_cfg(3'd0, 3'b000),
      row_req(FN_SUBMIT, 2'd2, 16'h7E57, 1),
      row_req(FN_FETCH,  2'd1, 16'h0000, 1),
      row_cfg(3'd4, 3'b000),
      row_req(FN_SPAWN,  2'd1, 16'h0000, QUEUE_DEPTH),
      row_req(FN_SPAWN,  2'd1, 16'h0001, 1),
      row_req(FN_SUBMIT, 2'd0, 16'h0000, 4),
      row_req(FN_FETCH,  2'd2, 16'h0000, 3),
      row_cfg(3'd1, 3'b000),
      row_req(FN_FETCH,  2'd0, 16'h0000, 4)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].cfg) begin
        settle();
        set_pool(script[i].workers, script[i].stop_word);
      end else begin
        for (int k = 0; k < script[i].reps; k++) begin
          r = script[i].req;
          if (script[i].reps > 1) r.task_handle = $urandom;
          send_request(r, script[i].typed, script[i].want);
        end
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       workers_w = 3'd4;
        1:       workers_w = 3'd1;
        default: workers_w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(1, 4);
      endcase
      stop_w = {2'($urandom_range(0, 3)), phase % 4 == 3};
      push_pct = (phase % 4 == 3) ? 15 : (phase % 2 == 1) ? 75 : 45;
      settle();
      set_pool(workers_w, stop_w);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) r.func = FN_UNUSED;
        else if (roll < push_pct) r.func = $urandom_range(0, 1) ? FN_SPAWN : FN_SUBMIT;
        else r.func = FN_FETCH;
        r.worker = $urandom_range(0, NUM_WORKERS - 1);
        r.task_handle = $urandom;
        send_request(r, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("work_stealing_task_scheduler regression: pass");
    end else begin
      $display("work_stealing_task_scheduler regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, 4);
      // hold off long enough to back the block up into its input
      if (!held && taken >= 400 && in_valid) begin
        stall = 150;
        held = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (outcomes_due.size() == 0) begin
        $error("result beat with no request outstanding");
        failures++;
      end else begin
        want = outcomes_due[0];
        outcomes_due.delete(0);
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.task_out !== want.task_out) begin
          $error("task_out: expected %0h, got %0h", want.task_out, out_data.task_out);
          failures++;
        end
        if (out_data.source_queue !== want.source_queue) begin
          $error("source_queue: expected %0d, got %0d", want.source_queue,
                 out_data.source_queue);
          failures++;
        end
        if (out_data.stolen !== want.stolen) begin
          $error("stolen: expected %0d, got %0d", want.stolen, out_data.stolen);
          failures++;
        end
        if (out_data.queued_total !== want.queued_total) begin
          $error("queued_total: expected %0d, got %0d", want.queued_total,
                 out_data.queued_total);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("work_stealing_task_scheduler regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+src
src/wsts_pkg.sv
src/wsts_ram.sv
src/wsts_sched.sv
src/work_stealing_task_scheduler.sv
src/wsts_checker.sv
sim/work_stealing_task_scheduler_test.sv
